>>> src/assert_macros.svh
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/i2cbb_pkg.sv
package i2cbb_pkg;

  localparam logic [2:0] OP_RECOVER = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_STOP    = 3'd2;
  localparam logic [2:0] OP_ACK     = 3'd3;
  localparam logic [2:0] OP_WRITE   = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  localparam logic [3:0] RECOVERY_LIMIT_RESET = 4'd8;
  localparam logic [3:0] BITS_PER_BYTE        = 4'd8;

  typedef enum logic [15:0] {
    PH_IDLE      = 16'b0000_0000_0000_0001,
    PH_REC_CHECK = 16'b0000_0000_0000_0010,
    PH_REC_PULSE = 16'b0000_0000_0000_0100,
    PH_S2        = 16'b0000_0000_0000_1000,
    PH_S3        = 16'b0000_0000_0001_0000,
    PH_P2        = 16'b0000_0000_0010_0000,
    PH_P3        = 16'b0000_0000_0100_0000,
    PH_A2        = 16'b0000_0000_1000_0000,
    PH_W_LOW     = 16'b0000_0001_0000_0000,
    PH_W_DATA    = 16'b0000_0010_0000_0000,
    PH_W_HIGH    = 16'b0000_0100_0000_0000,
    PH_W_END     = 16'b0000_1000_0000_0000,
    PH_R_LOW     = 16'b0001_0000_0000_0000,
    PH_R_HIGH    = 16'b0010_0000_0000_0000,
    PH_R_SAMPLE  = 16'b0100_0000_0000_0000,
    PH_R_END     = 16'b1000_0000_0000_0000
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       sda_in;
  } slot_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       ready_res;
    logic [7:0] read_data;
    logic       read_valid;
  } slot_out_t;

endpackage

>>> src/i2c_bit_bang_master.sv
// channel | dir | handshake            | beat
// in      | in  | in_valid / in_ready   | i2cbb_pkg::slot_in_t, one bus slot
// out     | out | out_valid / out_ready | i2cbb_pkg::slot_out_t, pin levels of the slot
// cfg     | in  | cfg_valid / cfg_ready | 4-bit recovery_limit
// one slot per cycle while in_ready is high: the sequencer step and the output register update on the same edge
// an in beat shows up as an out beat in the cycle after it is taken, through the output register
// in_ready drops only while a finished out beat waits on out_ready
// reset idles the sequencer, releases both lines and sets recovery_limit to 8
// cfg_ready is always high
`include "assert_macros.svh"

module i2c_bit_bang_master (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cbb_pkg::slot_in_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cbb_pkg::slot_out_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_data
);

  i2cbb_pkg::phase_t phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] current_op, current_op_next;
  logic [3:0] recovery_count, recovery_count_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic [3:0] recovery_limit;
  logic       rvalid;
  logic       in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    current_op_next     = current_op;
    recovery_count_next = recovery_count;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    rvalid              = 1'b0;
    unique case (phase)
      i2cbb_pkg::PH_IDLE: begin
        if (in_data.cmd_valid) begin
          unique case (in_data.operation)
            i2cbb_pkg::OP_RECOVER: begin
              current_op_next     = in_data.operation;
              sda_level_next      = 1'b1;
              recovery_count_next = '0;
              phase_next          = i2cbb_pkg::PH_REC_CHECK;
            end
            i2cbb_pkg::OP_START: begin
              current_op_next = in_data.operation;
              scl_level_next  = 1'b1;
              sda_level_next  = 1'b1;
              phase_next      = i2cbb_pkg::PH_S2;
            end
            i2cbb_pkg::OP_STOP: begin
              current_op_next = in_data.operation;
              scl_level_next  = 1'b0;
              sda_level_next  = 1'b0;
              phase_next      = i2cbb_pkg::PH_P2;
            end
            i2cbb_pkg::OP_ACK: begin
              current_op_next = in_data.operation;
              scl_level_next  = 1'b1;
              phase_next      = i2cbb_pkg::PH_A2;
            end
            i2cbb_pkg::OP_WRITE: begin
              current_op_next = in_data.operation;
              shift_byte_next = in_data.write_data;
              bit_count_next  = '0;
              scl_level_next  = 1'b0;
              phase_next      = i2cbb_pkg::PH_W_DATA;
            end
            i2cbb_pkg::OP_READ: begin
              current_op_next = in_data.operation;
              sda_level_next  = 1'b1;
              shift_byte_next = '0;
              bit_count_next  = '0;
              scl_level_next  = 1'b0;
              phase_next      = i2cbb_pkg::PH_R_HIGH;
            end
            default: begin
              phase_next = i2cbb_pkg::PH_IDLE;
            end
          endcase
        end
      end
      i2cbb_pkg::PH_REC_CHECK: begin
        if (!in_data.sda_in && (recovery_count < recovery_limit)) begin
          scl_level_next = 1'b0;
          phase_next     = i2cbb_pkg::PH_REC_PULSE;
        end else begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
          phase_next     = i2cbb_pkg::PH_IDLE;
        end
      end
      i2cbb_pkg::PH_REC_PULSE: begin
        scl_level_next      = 1'b1;
        recovery_count_next = recovery_count + 4'd1;
        phase_next          = i2cbb_pkg::PH_REC_CHECK;
      end
      i2cbb_pkg::PH_S2: begin
        sda_level_next = 1'b0;
        phase_next     = i2cbb_pkg::PH_S3;
      end
      i2cbb_pkg::PH_S3: begin
        scl_level_next = 1'b0;
        phase_next     = i2cbb_pkg::PH_IDLE;
      end
      i2cbb_pkg::PH_P2: begin
        scl_level_next = 1'b1;
        phase_next     = i2cbb_pkg::PH_P3;
      end
      i2cbb_pkg::PH_P3: begin
        sda_level_next = 1'b1;
        phase_next     = i2cbb_pkg::PH_IDLE;
      end
      i2cbb_pkg::PH_A2: begin
        scl_level_next = 1'b0;
        phase_next     = i2cbb_pkg::PH_IDLE;
      end
      i2cbb_pkg::PH_W_LOW: begin
        scl_level_next = 1'b0;
        phase_next     = i2cbb_pkg::PH_W_DATA;
      end
      i2cbb_pkg::PH_W_DATA: begin
        sda_level_next = shift_byte[7];
        phase_next     = i2cbb_pkg::PH_W_HIGH;
      end
      i2cbb_pkg::PH_W_HIGH: begin
        scl_level_next  = 1'b1;
        shift_byte_next = {shift_byte[6:0], 1'b0};
        bit_count_next  = bit_count + 4'd1;
        phase_next      = (bit_count_next >= i2cbb_pkg::BITS_PER_BYTE) ?
                          i2cbb_pkg::PH_W_END : i2cbb_pkg::PH_W_LOW;
      end
      i2cbb_pkg::PH_W_END: begin
        scl_level_next = 1'b0;
        phase_next     = i2cbb_pkg::PH_IDLE;
      end
      i2cbb_pkg::PH_R_LOW: begin
        scl_level_next = 1'b0;
        phase_next     = i2cbb_pkg::PH_R_HIGH;
      end
      i2cbb_pkg::PH_R_HIGH: begin
        scl_level_next = 1'b1;
        phase_next     = i2cbb_pkg::PH_R_SAMPLE;
      end
      i2cbb_pkg::PH_R_SAMPLE: begin
        shift_byte_next = {shift_byte[6:0], in_data.sda_in};
        bit_count_next  = bit_count + 4'd1;
        phase_next      = (bit_count_next >= i2cbb_pkg::BITS_PER_BYTE) ?
                          i2cbb_pkg::PH_R_END : i2cbb_pkg::PH_R_LOW;
      end
      i2cbb_pkg::PH_R_END: begin
        scl_level_next = 1'b0;
        rvalid         = 1'b1;
        phase_next     = i2cbb_pkg::PH_IDLE;
      end
      default: begin
        phase_next = i2cbb_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= i2cbb_pkg::PH_IDLE;
      bit_count      <= '0;
      shift_byte     <= '0;
      current_op     <= '0;
      recovery_count <= '0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
      recovery_limit <= i2cbb_pkg::RECOVERY_LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        recovery_limit <= cfg_data;
      end
      if (in_fire) begin
        phase          <= phase_next;
        bit_count      <= bit_count_next;
        shift_byte     <= shift_byte_next;
        current_op     <= current_op_next;
        recovery_count <= recovery_count_next;
        scl_level      <= scl_level_next;
        sda_level      <= sda_level_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.scl_out    <= scl_level_next;
      out_data.sda_out    <= sda_level_next;
      out_data.ready_res  <= (phase_next == i2cbb_pkg::PH_IDLE);
      out_data.read_data  <= rvalid ? shift_byte_next : 8'd0;
      out_data.read_valid <= rvalid;
    end
  end

  `ASSERT_HOLDS(a_read_ends_idle, clk, rst,
    (out_valid && out_data.read_valid) |-> out_data.ready_res, "read beat not idle")
  `ASSERT_HOLDS(a_bit_count_range, clk, rst, bit_count <= i2cbb_pkg::BITS_PER_BYTE,
    "bit count past byte")
  `ASSERT_NEXT(a_start_released, clk, rst,
    in_fire && (phase == i2cbb_pkg::PH_IDLE) && in_data.cmd_valid &&
    (in_data.operation == i2cbb_pkg::OP_START),
    out_valid && out_data.scl_out && out_data.sda_out && !out_data.ready_res,
    "start slot wrong")
  `ASSERT_NEXT(a_busy_ignores_cmd, clk, rst,
    in_fire && (phase != i2cbb_pkg::PH_IDLE), $stable(current_op), "command taken while busy")
  `ASSERT_HOLDS(a_recovery_bound, clk, rst,
    (phase == i2cbb_pkg::PH_REC_PULSE) |-> (recovery_count < recovery_limit),
    "recovery pulse past limit")

endmodule
